FILE: rtl/core/slws_pkg.sv
// ----------------------------------------------------------------------------
// Sleep scheduler package
// Shared types, codes and constants of the sleep lock and wake scheduler.
// ----------------------------------------------------------------------------
package slws_pkg;

  localparam int unsigned LockBits    = 16;
  localparam int unsigned MsPerSecond = 1000;
  localparam int unsigned PrescW      = (MsPerSecond > 1) ? $clog2(MsPerSecond) : 1;

  localparam logic [15:0]       LockMask  = 16'((64'd1 << LockBits) - 64'd1);
  localparam logic [PrescW-1:0] PrescLast = PrescW'(MsPerSecond - 1);
  localparam logic [11:0]       MinSleepS = 12'd10;
  localparam logic [11:0]       MaxSleepS = 12'd3600;
  localparam logic [19:0]       WakePeriodReset = 20'd86400;

  localparam int unsigned AddrW = 4;

  typedef enum logic [1:0] {
    REG_IDLE_DELAY  = 2'd0,
    REG_INHIBIT     = 2'd1,
    REG_WAKE_PERIOD = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_TICK      = 4'd0,
    OP_LOCK      = 4'd1,
    OP_UNLOCK    = 4'd2,
    OP_INHIBIT   = 4'd3,
    OP_DONE      = 4'd4,
    OP_IMMEDIATE = 4'd5,
    OP_RESTART   = 4'd6,
    OP_WAKE      = 4'd7,
    OP_LOAD_TS   = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ARMED   = 2'd1,
    EV_SLEEP   = 2'd2,
    EV_RESTART = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    CD_NONE    = 2'd0,
    CD_IDLE    = 2'd1,
    CD_INHIBIT = 2'd2
  } cd_kind_e;

  typedef struct packed {
    logic [15:0] idle_delay_ms;
    logic [15:0] inhibit_ms;
    logic [19:0] wake_period_s;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [15:0] lock_mask;
    logic [31:0] timestamp_value;
    logic        wake_by_timer;
    logic        network_saved;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [11:0] sleep_seconds;
    logic        inhibit_accepted;
    logic        report_due;
    logic [15:0] lock_state;
    logic [31:0] current_time;
  } result_t;

  // A period start of zero counts as unset; one later than now is pulled back.
  function automatic logic [31:0] pull_start(logic [31:0] start, logic [31:0] now);
    pull_start = ((start == 32'd0) || (start > now)) ? now : start;
  endfunction

endpackage

FILE: rtl/core/sleep_lock_and_wake_scheduler.sv
// ----------------------------------------------------------------------------
// Sleep lock and wake scheduler
// Input register, single-pass scheduler core and result register.
// ----------------------------------------------------------------------------
// A result enters the result register when its input transaction leaves the input register.
// One transaction per cycle when not stalled, set by the single input and result registers.
// An empty input register accepts a new transaction while a finished result waits.
// Reset clears the core, handshake and configuration registers to their reset values
// at once, but not the input and result data registers; there is no clearing pass.
module sleep_lock_and_wake_scheduler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slws_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [3:0]                  operation_i,
  input  logic [15:0]                 lock_mask_i,
  input  logic [31:0]                 timestamp_value_i,
  input  logic                        wake_by_timer_i,
  input  logic                        network_saved_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  event_kind_o,
  output logic [11:0]                 sleep_seconds_o,
  output logic                        inhibit_accepted_o,
  output logic                        report_due_o,
  output logic [15:0]                 lock_state_o,
  output logic [31:0]                 current_time_o
);

  slws_pkg::cfg_t    cfg;
  slws_pkg::item_t   item_q;
  slws_pkg::result_t res;
  slws_pkg::result_t res_q;
  logic in_vld_q;
  logic out_vld_q;
  logic advance;

  slws_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.operation       <= operation_i;
      item_q.lock_mask       <= lock_mask_i;
      item_q.timestamp_value <= timestamp_value_i;
      item_q.wake_by_timer   <= wake_by_timer_i;
      item_q.network_saved   <= network_saved_i;
    end
  end

  slws_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign event_kind_o       = res_q.event_kind;
  assign sleep_seconds_o    = res_q.sleep_seconds;
  assign inhibit_accepted_o = res_q.inhibit_accepted;
  assign report_due_o       = res_q.report_due;
  assign lock_state_o       = res_q.lock_state;
  assign current_time_o     = res_q.current_time;

endmodule

FILE: rtl/core/slws_regs.sv
// ----------------------------------------------------------------------------
// Sleep scheduler configuration registers
// APB register file holding the idle delay, inhibit window and wake period.
// ----------------------------------------------------------------------------
module slws_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slws_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output slws_pkg::cfg_t              cfg_o
);

  slws_pkg::cfg_t cfg_q, cfg_d;
  slws_pkg::reg_idx_e idx;
  logic wr_en;

  assign idx    = slws_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        slws_pkg::REG_IDLE_DELAY:  cfg_d.idle_delay_ms = pwdata[15:0];
        slws_pkg::REG_INHIBIT:     cfg_d.inhibit_ms    = pwdata[15:0];
        slws_pkg::REG_WAKE_PERIOD: cfg_d.wake_period_s = pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      slws_pkg::REG_IDLE_DELAY:  prdata = {16'd0, cfg_q.idle_delay_ms};
      slws_pkg::REG_INHIBIT:     prdata = {16'd0, cfg_q.inhibit_ms};
      slws_pkg::REG_WAKE_PERIOD: prdata = {12'd0, cfg_q.wake_period_s};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_delay_ms <= 16'd0;
      cfg_q.inhibit_ms    <= 16'd0;
      cfg_q.wake_period_s <= slws_pkg::WakePeriodReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/core/slws_sleep_len.sv
// ----------------------------------------------------------------------------
// Sleep scheduler sleep length
// Time left to the next wake report, clamped to the allowed sleep range.
// ----------------------------------------------------------------------------
module slws_sleep_len (
  input  logic [31:0] now_i,
  input  logic [31:0] period_start_i,
  input  logic [19:0] wake_period_s_i,
  output logic [31:0] period_start_o,
  output logic [11:0] sleep_len_o
);

  logic        pulled;
  logic [31:0] from_start;
  logic [19:0] left;

  assign pulled         = (period_start_i == 32'd0) || (period_start_i > now_i);
  assign period_start_o = pulled ? now_i : period_start_i;
  assign from_start     = pulled ? 32'd0 : (now_i - period_start_i);
  assign left           = wake_period_s_i - from_start[19:0];

  always_comb begin
    if (from_start >= {12'd0, wake_period_s_i}) begin
      sleep_len_o = slws_pkg::MinSleepS;
    end else if (left > {8'd0, slws_pkg::MaxSleepS}) begin
      sleep_len_o = slws_pkg::MaxSleepS;
    end else if (left < {8'd0, slws_pkg::MinSleepS}) begin
      sleep_len_o = slws_pkg::MinSleepS;
    end else begin
      sleep_len_o = left[11:0];
    end
  end

endmodule

FILE: rtl/core/slws_core.sv
// ----------------------------------------------------------------------------
// Sleep scheduler core
// Lock mask, shared countdown, seconds clock and wake bookkeeping; one
// transaction is processed whenever the update strobe is high.
// ----------------------------------------------------------------------------
module slws_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                update_i,
  input  slws_pkg::item_t     item_i,
  input  slws_pkg::cfg_t      cfg_i,
  output slws_pkg::result_t   result_o
);

  logic [15:0]                  lock_q, lock_d;
  logic                         inh_q, inh_d;
  logic                         rst_pend_q, rst_pend_d;
  slws_pkg::cd_kind_e           kind_q, kind_d;
  logic [15:0]                  left_q, left_d;
  logic [slws_pkg::PrescW-1:0]  presc_q, presc_d;
  logic [31:0]                  now_q, now_d;
  logic [31:0]                  ps_q, ps_d;
  logic [31:0]                  lst_q, lst_d;
  logic [11:0]                  lper_q, lper_d;
  logic                         halted_q, halted_d;

  logic [15:0] mask;
  logic        presc_wrap;
  logic [31:0] now_tick;
  logic [31:0] sleep_ps;
  logic [11:0] sleep_len;
  logic [31:0] wake_base;
  logic [31:0] wake_ps;
  logic [31:0] wake_now;
  logic        wake_pulled;
  logic [31:0] wake_diff;
  logic        wake_rep;

  assign mask       = item_i.lock_mask & slws_pkg::LockMask;
  assign presc_wrap = (presc_q == slws_pkg::PrescLast);
  assign now_tick   = now_q + {31'd0, presc_wrap};

  slws_sleep_len u_sleep_len (
    .now_i           (now_tick),
    .period_start_i  (ps_q),
    .wake_period_s_i (cfg_i.wake_period_s),
    .period_start_o  (sleep_ps),
    .sleep_len_o     (sleep_len)
  );

  assign wake_base   = halted_q ? lst_q : now_q;
  assign wake_ps     = halted_q ? slws_pkg::pull_start(ps_q, lst_q) : ps_q;
  assign wake_now    = wake_base + {20'd0, lper_q};
  assign wake_pulled = (wake_ps == 32'd0) || (wake_ps > wake_now);
  assign wake_diff   = wake_pulled ? 32'd0 : (wake_now - wake_ps);
  assign wake_rep    = (wake_diff >= {12'd0, cfg_i.wake_period_s});

  always_comb begin
    lock_d     = lock_q;
    inh_d      = inh_q;
    rst_pend_d = rst_pend_q;
    kind_d     = kind_q;
    left_d     = left_q;
    presc_d    = presc_q;
    now_d      = now_q;
    ps_d       = ps_q;
    lst_d      = lst_q;
    lper_d     = lper_q;
    halted_d   = halted_q;
    result_o.event_kind       = slws_pkg::EV_NONE;
    result_o.sleep_seconds    = 12'd0;
    result_o.inhibit_accepted = 1'b0;
    result_o.report_due       = 1'b0;

    if (item_i.operation == slws_pkg::OP_WAKE) begin
      if (halted_q) begin
        halted_d   = 1'b0;
        lock_d     = 16'd0;
        inh_d      = 1'b0;
        rst_pend_d = 1'b0;
        kind_d     = slws_pkg::CD_NONE;
        left_d     = 16'd0;
        presc_d    = '0;
      end
      now_d = wake_base;
      ps_d  = wake_ps;
      if (item_i.wake_by_timer) begin
        now_d = wake_now;
        ps_d  = (wake_rep || wake_pulled) ? wake_now : wake_ps;
        result_o.report_due = wake_rep;
      end
    end else if (!halted_q) begin
      case (item_i.operation) inside
        slws_pkg::OP_TICK: begin
          presc_d = presc_wrap ? '0 : presc_q + 1'b1;
          now_d   = now_tick;
          if (kind_q != slws_pkg::CD_NONE) begin
            if (left_q <= 16'd1) begin
              kind_d = slws_pkg::CD_NONE;
              left_d = 16'd0;
              if (kind_q == slws_pkg::CD_INHIBIT) begin
                inh_d = 1'b0;
                if (lock_q == 16'd0) begin
                  kind_d = slws_pkg::CD_IDLE;
                  left_d = cfg_i.idle_delay_ms;
                  result_o.event_kind = slws_pkg::EV_ARMED;
                end
              end else if (rst_pend_q) begin
                result_o.event_kind = slws_pkg::EV_RESTART;
                halted_d = 1'b1;
              end else begin
                result_o.event_kind = slws_pkg::EV_SLEEP;
                halted_d = 1'b1;
                if (item_i.network_saved) begin
                  result_o.sleep_seconds = sleep_len;
                  lst_d  = now_tick;
                  ps_d   = sleep_ps;
                  lper_d = sleep_len;
                end
              end
            end else begin
              left_d = left_q - 16'd1;
            end
          end
        end
        slws_pkg::OP_LOCK: begin
          lock_d = lock_q | mask;
          if ((lock_d != 16'd0) && !inh_q) begin
            kind_d = slws_pkg::CD_NONE;
            left_d = 16'd0;
          end
        end
        slws_pkg::OP_UNLOCK: begin
          lock_d = lock_q & ~mask;
          if (!inh_q && (lock_d == 16'd0)) begin
            kind_d = slws_pkg::CD_IDLE;
            left_d = cfg_i.idle_delay_ms;
            result_o.event_kind = slws_pkg::EV_ARMED;
          end
        end
        slws_pkg::OP_INHIBIT: begin
          if (cfg_i.inhibit_ms != 16'd0) begin
            kind_d = slws_pkg::CD_INHIBIT;
            left_d = cfg_i.inhibit_ms;
            inh_d  = 1'b1;
            result_o.inhibit_accepted = 1'b1;
          end
        end
        slws_pkg::OP_DONE, slws_pkg::OP_IMMEDIATE: begin
          if (((item_i.operation == slws_pkg::OP_DONE) && (cfg_i.inhibit_ms != 16'd0)) ||
              ((item_i.operation == slws_pkg::OP_IMMEDIATE) && inh_q)) begin
            kind_d = slws_pkg::CD_NONE;
            left_d = 16'd0;
            inh_d  = 1'b0;
            if (lock_q == 16'd0) begin
              kind_d = slws_pkg::CD_IDLE;
              left_d = cfg_i.idle_delay_ms;
              result_o.event_kind = slws_pkg::EV_ARMED;
            end
          end
        end
        slws_pkg::OP_RESTART: begin
          rst_pend_d = 1'b1;
        end
        slws_pkg::OP_LOAD_TS: begin
          now_d = item_i.timestamp_value;
          ps_d  = slws_pkg::pull_start(ps_q, item_i.timestamp_value);
        end
        default: ;
      endcase
    end

    result_o.lock_state   = lock_d;
    result_o.current_time = now_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q     <= 16'd0;
      inh_q      <= 1'b0;
      rst_pend_q <= 1'b0;
      kind_q     <= slws_pkg::CD_NONE;
      left_q     <= 16'd0;
      presc_q    <= '0;
      now_q      <= 32'd0;
      ps_q       <= 32'd0;
      lst_q      <= 32'd0;
      lper_q     <= 12'd0;
      halted_q   <= 1'b0;
    end else if (update_i) begin
      lock_q     <= lock_d;
      inh_q      <= inh_d;
      rst_pend_q <= rst_pend_d;
      kind_q     <= kind_d;
      left_q     <= left_d;
      presc_q    <= presc_d;
      now_q      <= now_d;
      ps_q       <= ps_d;
      lst_q      <= lst_d;
      lper_q     <= lper_d;
      halted_q   <= halted_d;
    end
  end

endmodule

FILE: rtl/core/slws_checker.sv
// ----------------------------------------------------------------------------
// Sleep scheduler checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module slws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  event_kind_o,
  input logic [11:0] sleep_seconds_o,
  input logic        inhibit_accepted_o,
  input logic        report_due_o,
  input logic [15:0] lock_state_o,
  input logic [31:0] current_time_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o) &&
      $stable(sleep_seconds_o) && $stable(lock_state_o) && $stable(current_time_o))
    else $error("result changed while stalled");

  a_secs_only_sleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != slws_pkg::EV_SLEEP) |-> sleep_seconds_o == 12'd0)
    else $error("sleep length given without a deep sleep");

  a_secs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sleep_seconds_o != 12'd0) |->
      (sleep_seconds_o >= slws_pkg::MinSleepS) && (sleep_seconds_o <= slws_pkg::MaxSleepS))
    else $error("sleep length out of range");

  a_flags_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (inhibit_accepted_o || report_due_o) |->
      (event_kind_o == slws_pkg::EV_NONE) && !(inhibit_accepted_o && report_due_o))
    else $error("inhibit or report flag with another event");

endmodule

bind sleep_lock_and_wake_scheduler slws_checker u_slws_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .event_kind_o       (event_kind_o),
  .sleep_seconds_o    (sleep_seconds_o),
  .inhibit_accepted_o (inhibit_accepted_o),
  .report_due_o       (report_due_o),
  .lock_state_o       (lock_state_o),
  .current_time_o     (current_time_o)
);

FILE: tb/tb_sleep_lock_and_wake_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep lock and wake scheduler testbench
// Sends lock, unlock, inhibit, tick, wake, timestamp and other commands through the
// valid/ready input and sets the delays over APB between phases. A scoreboard
// class keeps its own copy of the scheduler state and the register values,
// and checks every result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_sleep_lock_and_wake_scheduler;
  import slws_pkg::*;

  localparam int unsigned RandomItems = 380;
  localparam int unsigned LongHold    = 150;

  class sleep_sched_scoreboard;
    logic [15:0] idle_delay_ms;
    logic [15:0] inhibit_ms;
    logic [19:0] wake_period_s;

    logic [15:0] lock_causes;
    bit          inhibit_active;
    bit          restart_pending;
    cd_kind_e    cd_kind;
    logic [15:0] cd_left;
    int unsigned prescale;
    logic [31:0] base_time;
    logic [31:0] elapsed_s;
    logic [31:0] period_start;
    logic [31:0] last_sleep_time;
    logic [11:0] last_period;
    bit          halted;

    result_t     expected_reports[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned commands;
    int unsigned useful_items;
    int unsigned n_armed;
    int unsigned n_sleep;
    int unsigned n_restart;
    int unsigned n_report;

    function new();
      idle_delay_ms   = '0;
      inhibit_ms      = '0;
      wake_period_s   = WakePeriodReset;
      lock_causes     = '0;
      inhibit_active  = 1'b0;
      restart_pending = 1'b0;
      cd_kind         = CD_NONE;
      cd_left         = '0;
      prescale        = 0;
      base_time       = '0;
      elapsed_s       = '0;
      period_start    = '0;
      last_sleep_time = '0;
      last_period     = '0;
      halted          = 1'b0;
      errors          = 0;
      checked         = 0;
      commands        = 0;
      useful_items    = 0;
      n_armed         = 0;
      n_sleep         = 0;
      n_restart       = 0;
      n_report        = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [31:0] data);
      case (idx)
        REG_IDLE_DELAY:  idle_delay_ms = data[15:0];
        REG_INHIBIT:     inhibit_ms = data[15:0];
        REG_WAKE_PERIOD: wake_period_s = data[19:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(reg_idx_e idx);
      case (idx)
        REG_IDLE_DELAY:  return {16'd0, idle_delay_ms};
        REG_INHIBIT:     return {16'd0, inhibit_ms};
        REG_WAKE_PERIOD: return {12'd0, wake_period_s};
        default:         return '0;
      endcase
    endfunction

    function void fail_note(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function logic [31:0] now_s();
      return base_time + elapsed_s;
    endfunction

    function void pull_start_to(logic [31:0] t);
      if (period_start == 32'd0 || period_start > t) period_start = t;
    endfunction

    function void load_base(logic [31:0] t);
      base_time = t;
      elapsed_s = '0;
      pull_start_to(t);
    endfunction

    function logic [11:0] sleep_length();
      logic [31:0] t;
      logic [31:0] from_start;
      logic [31:0] len;
      t = now_s();
      last_sleep_time = t;
      pull_start_to(t);
      from_start = t - period_start;
      if (from_start >= {12'd0, wake_period_s}) begin
        len = 32'(MinSleepS);
      end else begin
        len = {12'd0, wake_period_s} - from_start;
        if (len > 32'(MaxSleepS)) len = 32'(MaxSleepS);
        if (len < 32'(MinSleepS)) len = 32'(MinSleepS);
      end
      last_period = len[11:0];
      return len[11:0];
    endfunction

    function logic [1:0] arm_if_free();
      if (inhibit_active || lock_causes != 16'd0) return EV_NONE;
      cd_kind = CD_IDLE;
      cd_left = idle_delay_ms;
      return EV_ARMED;
    endfunction

    function result_t predict_report(item_t it);
      result_t     r;
      cd_kind_e    kind;
      logic [31:0] t;
      r = '0;
      if (halted && it.operation == OP_WAKE) begin
        halted          = 1'b0;
        lock_causes     = '0;
        inhibit_active  = 1'b0;
        restart_pending = 1'b0;
        cd_kind         = CD_NONE;
        cd_left         = '0;
        prescale        = 0;
        load_base(last_sleep_time);
      end
      if (!halted) begin
        case (it.operation) inside
          OP_TICK: begin
            prescale++;
            if (prescale >= MsPerSecond) begin
              prescale = 0;
              elapsed_s++;
            end
            if (cd_kind != CD_NONE) begin
              if (cd_left <= 16'd1) begin
                kind    = cd_kind;
                cd_kind = CD_NONE;
                cd_left = '0;
                if (kind == CD_INHIBIT) begin
                  inhibit_active = 1'b0;
                  r.event_kind   = arm_if_free();
                end else if (restart_pending) begin
                  r.event_kind = EV_RESTART;
                  halted       = 1'b1;
                end else begin
                  r.event_kind    = EV_SLEEP;
                  r.sleep_seconds = it.network_saved ? sleep_length() : 12'd0;
                  halted          = 1'b1;
                end
              end else begin
                cd_left--;
              end
            end
          end
          OP_LOCK: begin
            lock_causes |= it.lock_mask;
            if (lock_causes != 16'd0 && !inhibit_active) begin
              cd_kind = CD_NONE;
              cd_left = '0;
            end
          end
          OP_UNLOCK: begin
            lock_causes &= ~it.lock_mask;
            r.event_kind = arm_if_free();
          end
          OP_INHIBIT: begin
            if (inhibit_ms != 16'd0) begin
              cd_kind            = CD_INHIBIT;
              cd_left            = inhibit_ms;
              inhibit_active     = 1'b1;
              r.inhibit_accepted = 1'b1;
            end
          end
          OP_DONE, OP_IMMEDIATE: begin
            if ((it.operation == OP_DONE && inhibit_ms != 16'd0) ||
                (it.operation == OP_IMMEDIATE && inhibit_active)) begin
              cd_kind        = CD_NONE;
              cd_left        = '0;
              inhibit_active = 1'b0;
              r.event_kind   = arm_if_free();
            end
          end
          OP_RESTART: restart_pending = 1'b1;
          OP_WAKE: begin
            if (it.wake_by_timer) begin
              load_base(now_s() + {20'd0, last_period});
              t = now_s();
              if (t >= period_start && (t - period_start) >= {12'd0, wake_period_s}) begin
                period_start = t;
                r.report_due = 1'b1;
              end
            end
          end
          OP_LOAD_TS: load_base(it.timestamp_value);
          default: ;
        endcase
      end
      r.lock_state   = lock_causes;
      r.current_time = now_s();
      return r;
    endfunction

    function void note_command(item_t it);
      result_t r;
      commands++;
      if (!(halted && it.operation != OP_WAKE) && it.operation <= OP_LOAD_TS) useful_items++;
      r = predict_report(it);
      case (r.event_kind)
        EV_ARMED:   n_armed++;
        EV_SLEEP:   n_sleep++;
        EV_RESTART: n_restart++;
        default: ;
      endcase
      if (r.report_due) n_report++;
      expected_reports.push_back(r);
    endfunction

    function void field_check(string name, longint unsigned want, longint unsigned got);
      if (want != got) fail_note($sformatf("%s: expected %0h, actual %0h", name, want, got));
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        fail_note("result transaction with no expectation pending");
        return;
      end
      want = expected_reports.pop_front();
      checked++;
      field_check("event_kind", 64'(want.event_kind), 64'(got.event_kind));
      field_check("sleep_seconds", 64'(want.sleep_seconds), 64'(got.sleep_seconds));
      field_check("inhibit_accepted", 64'(want.inhibit_accepted),
                  64'(got.inhibit_accepted));
      field_check("report_due", 64'(want.report_due), 64'(got.report_due));
      field_check("lock_state", 64'(want.lock_state), 64'(got.lock_state));
      field_check("current_time", 64'(want.current_time), 64'(got.current_time));
    endfunction
  endclass

  logic              clk_i              = 1'b0;
  logic              rst_ni             = 1'b0;
  logic              psel               = 1'b0;
  logic              penable            = 1'b0;
  logic              pwrite             = 1'b0;
  logic [AddrW-1:0]  paddr              = '0;
  logic [31:0]       pwdata             = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i         = 1'b0;
  logic              in_ready_o;
  logic [3:0]        operation_i        = '0;
  logic [15:0]       lock_mask_i        = '0;
  logic [31:0]       timestamp_value_i  = '0;
  logic              wake_by_timer_i    = 1'b0;
  logic              network_saved_i    = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i        = 1'b0;
  logic [1:0]        event_kind_o;
  logic [11:0]       sleep_seconds_o;
  logic              inhibit_accepted_o;
  logic              report_due_o;
  logic [15:0]       lock_state_o;
  logic [31:0]       current_time_o;

  sleep_sched_scoreboard sb;
  bit          tx_gaps          = 1'b0;
  bit          rx_stalls        = 1'b0;
  int unsigned long_holds_asked = 0;
  int unsigned n_phases         = 0;
  logic [31:0] stamp_base       = '0;

  sleep_lock_and_wake_scheduler DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .lock_mask_i        (lock_mask_i),
    .timestamp_value_i  (timestamp_value_i),
    .wake_by_timer_i    (wake_by_timer_i),
    .network_saved_i    (network_saved_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .event_kind_o       (event_kind_o),
    .sleep_seconds_o    (sleep_seconds_o),
    .inhibit_accepted_o (inhibit_accepted_o),
    .report_due_o       (report_due_o),
    .lock_state_o       (lock_state_o),
    .current_time_o     (current_time_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] rand_stamp();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return stamp_base + $urandom_range(0, 4000);
      2:       return 32'($urandom_range(0, 50));
      default: return 32'hFFFF_FFFF - $urandom_range(0, 100);
    endcase
  endfunction

  function automatic logic [15:0] rand_mask();
    case ($urandom_range(0, 2))
      0:       return 16'($urandom_range(1, 65535));
      1:       return 16'd1 << $urandom_range(0, 15);
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [19:0] rand_period();
    case ($urandom_range(0, 2))
      0:       return 20'($urandom_range(1, 30));
      1:       return 20'($urandom_range(3000, 5000));
      default: return 20'($urandom_range(1, 1048575));
    endcase
  endfunction

  function automatic logic [3:0] rand_op();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(int'(OP_LOAD_TS) + 1, 15));
    return 4'($urandom_range(int'(OP_TICK), int'(OP_LOAD_TS)));
  endfunction

  task automatic send(input logic [3:0] op, input logic [15:0] mask, input logic [31:0] stamp,
                      input logic by_timer, input logic net_saved);
    item_t it;
    it.operation       = op;
    it.lock_mask       = mask;
    it.timestamp_value = stamp;
    it.wake_by_timer   = by_timer;
    it.network_saved   = net_saved;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= it.operation;
    lock_mask_i       <= it.lock_mask;
    timestamp_value_i <= it.timestamp_value;
    wake_by_timer_i   <= it.wake_by_timer;
    network_saved_i   <= it.network_saved;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(it);
  endtask

  task automatic send_op(input logic [3:0] op, input logic [15:0] mask);
    send(op, mask, rand_stamp(), 1'($urandom), $urandom_range(0, 3) != 0);
  endtask

  task automatic tick_until_halted(input int unsigned limit);
    int unsigned n;
    n = 0;
    while (!sb.halted && n < limit) begin
      send_op(OP_TICK, rand_mask());
      n++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input reg_idx_e idx, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] idle_ms, input logic [15:0] inhibit,
                           input logic [19:0] period);
    logic [31:0] readback;
    wait_drained();
    apb_write(REG_IDLE_DELAY, {16'($urandom), idle_ms});
    apb_write(REG_INHIBIT, {16'($urandom), inhibit});
    apb_write(REG_WAKE_PERIOD, {12'($urandom), period});
    for (int i = REG_IDLE_DELAY; i <= REG_WAKE_PERIOD; i++) begin
      apb_read(reg_idx_e'(i), readback);
      if (readback !== sb.register_value(reg_idx_e'(i)))
        sb.fail_note($sformatf("register %0d read back: expected %0h, actual %0h",
                               i, sb.register_value(reg_idx_e'(i)), readback));
    end
    n_phases++;
  endtask

  task automatic run_directed();
    send(OP_LOCK, 16'hFFFF, 32'h0, 1'b0, 1'b1);
    send(OP_INHIBIT, 16'h0, 32'h0, 1'b0, 1'b1);
    send(OP_DONE, 16'h0, 32'h0, 1'b0, 1'b1);
    send(OP_IMMEDIATE, 16'h0, 32'h0, 1'b0, 1'b1);
    send(OP_UNLOCK, 16'h0001, 32'h0, 1'b0, 1'b1);
    send(OP_LOAD_TS, 16'h0, 32'hFFFF_FFF0, 1'b0, 1'b1);
    send(OP_UNLOCK, 16'hFFFF, 32'h0, 1'b0, 1'b1);
    send(OP_TICK, 16'h0, 32'h0, 1'b0, 1'b1);
    send(OP_TICK, 16'h0, 32'h0, 1'b0, 1'b1);
    send(OP_LOCK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send(OP_WAKE, 16'h0, 32'h0, 1'b1, 1'b1);
    send(4'hF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    configure(16'd2, 16'd3, 20'd1);
    send(OP_RESTART, 16'h0, 32'h0, 1'b0, 1'b0);
    send(OP_INHIBIT, 16'h0, 32'h0, 1'b0, 1'b0);
    send(OP_LOCK, 16'h8000, 32'h0, 1'b0, 1'b0);
    send(OP_UNLOCK, 16'h8000, 32'h0, 1'b0, 1'b0);
    repeat (5) send(OP_TICK, 16'h0, 32'h0, 1'b0, 1'b1);
    send(OP_WAKE, 16'h0, 32'h0, 1'b0, 1'b0);
    send(OP_WAKE, 16'h0, 32'h0, 1'b1, 1'b0);
    send(OP_INHIBIT, 16'h0, 32'h0, 1'b0, 1'b0);
    send(OP_IMMEDIATE, 16'h0, 32'h0, 1'b0, 1'b0);
    send(OP_LOAD_TS, 16'h0, 32'h0, 1'b0, 1'b0);
    repeat (2) send(OP_TICK, 16'h0, 32'h0, 1'b0, 1'b0);
    send(OP_WAKE, 16'h0, 32'h0, 1'b1, 1'b0);
  endtask

  task automatic run_sequence();
    int unsigned pick;
    logic [15:0] held;
    logic [3:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ($urandom_range(0, 1) == 1) send_op(OP_LOAD_TS, rand_mask());
      held = rand_mask();
      send_op(OP_LOCK, held);
      if ($urandom_range(0, 3) == 0) send_op(OP_RESTART, rand_mask());
      if ($urandom_range(0, 2) == 0) send_op(OP_INHIBIT, rand_mask());
      if ($urandom_range(0, 1) == 1) send_op(OP_UNLOCK, held & rand_mask());
      send_op(OP_UNLOCK, held);
      tick_until_halted(40);
      if (sb.halted) begin
        repeat ($urandom_range(0, 2)) begin
          op = rand_op();
          send_op((op == OP_WAKE) ? OP_TICK : op, rand_mask());
        end
        send(OP_WAKE, rand_mask(), rand_stamp(), $urandom_range(0, 3) != 0, 1'($urandom));
      end
    end else if (pick < 60) begin
      send_op(OP_INHIBIT, rand_mask());
      repeat ($urandom_range(0, 3))
        send_op($urandom_range(0, 1) == 1 ? OP_LOCK : OP_UNLOCK, rand_mask());
      case ($urandom_range(0, 2))
        0:       send_op(OP_DONE, rand_mask());
        1:       send_op(OP_IMMEDIATE, rand_mask());
        default: tick_until_halted(15);
      endcase
    end else if (pick < 75) begin
      send_op(OP_LOAD_TS, rand_mask());
      send_op(OP_WAKE, rand_mask());
      tick_until_halted($urandom_range(0, 3));
    end else begin
      repeat ($urandom_range(1, 4)) send_op(rand_op(), 16'($urandom));
    end
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned long_holds_done;
    result_t     got;
    hold_left       = 0;
    long_holds_done = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.event_kind       = event_kind_o;
        got.sleep_seconds    = sleep_seconds_o;
        got.inhibit_accepted = inhibit_accepted_o;
        got.report_due       = report_due_o;
        got.lock_state       = lock_state_o;
        got.current_time     = current_time_o;
        sb.check_report(got);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (long_holds_asked > long_holds_done) begin
        long_holds_done++;
        hold_left = LongHold - 1;
        out_ready_i <= 1'b0;
      end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned phase_end;
    int unsigned p;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    run_directed();

    // A longer idle delay, so that the countdown runs for many ticks before sleep.
    configure(16'd40, 16'd4, 20'd3000);
    send(OP_LOAD_TS, 16'h0, 32'd5000, 1'b0, 1'b1);
    send_op(OP_UNLOCK, 16'hFFFF);
    tick_until_halted(60);
    send(OP_WAKE, 16'h0, 32'h0, 1'b1, 1'b1);

    target = sb.commands + RandomItems;
    p = 0;
    while (sb.commands < target) begin
      if (target - sb.commands > 60) begin
        tx_gaps   = $urandom_range(0, 3) != 0;
        rx_stalls = $urandom_range(0, 3) != 0;
        if (p == 0) configure(16'hFFFF, 16'hFFFF, 20'hFFFFF);
        else if (p == 1) configure(16'd0, 16'd0, 20'd0);
        else configure(16'($urandom_range(0, 12)), 16'($urandom_range(0, 10)), rand_period());
        if (p == 0) long_holds_asked++;
        stamp_base = $urandom;
        p++;
      end
      phase_end = sb.commands + 60;
      while (sb.commands < phase_end && sb.commands < target) begin
        if (target - sb.commands <= 60) begin
          tx_gaps   = 1'b0;
          rx_stalls = 1'b0;
        end
        run_sequence();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("Run covered %0d commands (%0d acted on) over %0d register settings,",
             sb.commands, sb.useful_items, n_phases);
    $display("%0d results checked; seen %0d idle countdowns armed, %0d deep sleeps,",
             sb.checked, sb.n_armed, sb.n_sleep);
    $display("%0d restarts and %0d wake reports.", sb.n_restart, sb.n_report);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches in total.", sb.errors);
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d results outstanding.", sb.pending());
    $display("FAIL");
    $finish;
  end

endmodule
